// ===== design/sarc_pkg.sv =====
// Shared types, codes and helper function of the set-associative read cache.
`default_nettype none
package sarc_pkg;

	localparam int WORD_W  = 32;
	localparam int CNT_W   = 32;
	localparam int STAMP_W = 32;
	localparam int ADDR_W  = 9;
	localparam int SIZE_W  = 2;
	localparam int MIDX_W  = 7;
	localparam int CAC_W   = 8;
	localparam int MAC_W   = 10;
	localparam int LEN_W   = 3;

	// Function codes of an input beat.
	localparam logic FUNC_MEM_WRITE  = 1'b0;
	localparam logic FUNC_CACHE_READ = 1'b1;

	// Access size codes.
	localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
	localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
	localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

	// Register indexes on the configuration port.
	localparam logic REG_CACHE_COST = 1'b0;
	localparam logic REG_MEM_COST   = 1'b1;

	localparam logic [CAC_W-1:0] CAC_RESET = 8'd1;
	localparam logic [MAC_W-1:0] MAC_RESET = 10'd100;

	// Write port of the backing word memory.
	typedef struct packed {
		logic              en;
		logic [MIDX_W-1:0] index;
		logic [WORD_W-1:0] data;
	} mem_wr_t;

	// Number of bytes moved by an access; the reserved code moves none.
	function automatic logic [LEN_W-1:0] size_bytes(input logic [SIZE_W-1:0] sz);
		logic [LEN_W-1:0] len;
		case (sz)
			SIZE_BYTE: len = 3'd1;
			SIZE_HALF: len = 3'd2;
			SIZE_WORD: len = 3'd4;
			default:   len = 3'd0;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

// ===== design/sarc_word_mem.sv =====
// Backing word memory: one guarded write port and one registered read port.
`default_nettype none
module sarc_word_mem #(
	parameter int MEM_WORDS = 128
) (
	input  wire                             clk,
	input  wire sarc_pkg::mem_wr_t          wr,
	input  wire                             rd_en,
	input  wire  [$clog2(MEM_WORDS)-1:0]    rd_addr,
	output logic [sarc_pkg::WORD_W-1:0]     rdata
);

	localparam int MEM_AW = $clog2(MEM_WORDS);

	logic [sarc_pkg::WORD_W-1:0] mem [MEM_WORDS];

	// A write whose index lies beyond the memory is dropped.
	always_ff @(posedge clk) begin
		if (wr.en && (32'(wr.index) < MEM_WORDS)) begin
			mem[MEM_AW'(wr.index)] <= wr.data;
		end
		if (rd_en) begin
			rdata <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== design/set_assoc_read_cache_lru_unit.sv =====
// Top level of the set-associative read cache with least-recently-used replacement.
//
// Usage: an item is accepted at a rising edge where start is high and busy is low.
// A memory-write beat (func 0) stores mem_word_data into the backing word memory
// and gives its result beat on the next cycle. A cache-read beat (func 1) looks up
// byte_address; its result beat carries the zero-extended little-endian value, the
// hit flag and the running hit, miss, byte and cycle totals.
// Every result beat is shown for exactly one cycle with done high; the receiver
// cannot stall, so results are never held back or queued.
// Steps: a write stores its word at accept; a read hit does one cache-row read, then
// compare, select and stamp write-back. A miss adds a fill that reads the backing
// memory one word per cycle through its single port, alongside a walk of the ways
// for the oldest stamp when the set is full, and then writes the new line back.
// One item is in flight at a time, and busy drops in the cycle its result beat
// is shown.
// Reset clears the valid bits, the access clock and the totals, and loads the
// cost registers with 1 and 100; the cache rows and the backing memory are not
// cleared, and no read may fill from a backing word never written.
// Configuration writes through the APB port are taken at any time the block is idle.
`default_nettype none
module set_assoc_read_cache_lru_unit #(
	parameter int NUM_SETS   = 4,
	parameter int NUM_WAYS   = 2,
	parameter int LINE_BYTES = 8,
	parameter int MEM_WORDS  = 128
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [2:0]                        paddr,
	input  wire  [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  wire                               start,
	output logic                              busy,
	input  wire                               func,
	input  wire  [sarc_pkg::ADDR_W-1:0]       byte_address,
	input  wire  [sarc_pkg::SIZE_W-1:0]       access_size,
	input  wire  [sarc_pkg::MIDX_W-1:0]       mem_word_index,
	input  wire  [sarc_pkg::WORD_W-1:0]       mem_word_data,
	output logic                              done,
	output logic [sarc_pkg::WORD_W-1:0]       read_value,
	output logic                              was_hit,
	output logic [sarc_pkg::CNT_W-1:0]        hits_total,
	output logic [sarc_pkg::CNT_W-1:0]        misses_total,
	output logic [sarc_pkg::CNT_W-1:0]        bytes_total,
	output logic [sarc_pkg::CNT_W-1:0]        cycles_total
);

	localparam int ADDR_W    = sarc_pkg::ADDR_W;
	localparam int STAMP_W   = sarc_pkg::STAMP_W;
	localparam int WORD_W    = sarc_pkg::WORD_W;
	localparam int LINE_BITS = LINE_BYTES * 8;
	localparam int WPL       = LINE_BYTES / 4;
	localparam int OFF_W     = $clog2(LINE_BYTES);
	localparam int WPL_SH    = $clog2(WPL);
	localparam int SET_IW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_IW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int TAG_RAW   = ADDR_W - OFF_W - $clog2(NUM_SETS);
	localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int BLK_W     = ADDR_W - OFF_W;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int FILL_W    = MEM_AW + ADDR_W;
	localparam int IS_W      = $clog2(WPL + 1);
	localparam int WI_W      = (WPL > 1) ? WPL_SH : 1;
	localparam int POS_W     = OFF_W + 2;
	localparam int WAY_W     = LINE_BITS + TAG_W + STAMP_W;
	localparam int DATA_LSB  = 0;
	localparam int TAG_LSB   = LINE_BITS;
	localparam int STAMP_LSB = LINE_BITS + TAG_W;

	// One cache row holds every way of a set: line bytes, tag and stamp.
	typedef logic [NUM_WAYS-1:0][WAY_W-1:0] row_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_FILL,
		S_FINISH
	} state_t;

	state_t                         state_q;
	row_t                           cache_mem [NUM_SETS];
	row_t                           row_q;
	row_t                           cache_wdata;
	logic                           cache_we;
	logic                           cache_re;
	logic [NUM_WAYS-1:0]            valid_q [NUM_SETS];

	logic [sarc_pkg::CAC_W-1:0]     cac_q;
	logic [sarc_pkg::MAC_W-1:0]     mac_q;
	logic [STAMP_W-1:0]             clock_q;
	logic [sarc_pkg::CNT_W-1:0]     hits_q;
	logic [sarc_pkg::CNT_W-1:0]     misses_q;
	logic [sarc_pkg::CNT_W-1:0]     bytes_q;
	logic [sarc_pkg::CNT_W-1:0]     cycles_q;
	logic                           done_q;
	logic [WORD_W-1:0]              read_value_q;
	logic                           was_hit_q;

	// Request fields held for the whole access.
	logic [OFF_W-1:0]               off_s1;
	logic [SET_IW-1:0]              set_s1;
	logic [TAG_W-1:0]               tag_s1;
	logic [BLK_W-1:0]               blk_s1;
	logic [sarc_pkg::SIZE_W-1:0]    size_s1;

	// Fill and victim search.
	logic [IS_W-1:0]                iss_q;
	logic                           rv_q;
	logic [WI_W-1:0]                widx_q;
	logic [LINE_BITS-1:0]           fill_q;
	logic                           srch_done_q;
	logic [WAY_IW-1:0]              sw_q;
	logic [WAY_IW-1:0]              vic_q;
	logic [STAMP_W-1:0]             best_q;

	logic [BLK_W-1:0]               in_blk;
	logic [SET_IW-1:0]              in_set;
	logic [NUM_WAYS-1:0]            vrow;
	logic [NUM_WAYS-1:0]            hit_vec;
	logic                           any_hit;
	logic [WAY_IW-1:0]              hit_way;
	logic                           any_free;
	logic [WAY_IW-1:0]              free_way;
	logic [STAMP_W-1:0]             cur_stamp;
	logic [sarc_pkg::LEN_W-1:0]     len;
	logic [LINE_BITS-1:0]           line_sel;
	logic [WORD_W-1:0]              ext_val;
	logic [FILL_W-1:0]              fidx;
	logic                           mem_re;
	logic [MEM_AW-1:0]              mem_raddr;
	logic [WORD_W-1:0]              mem_rdata;
	sarc_pkg::mem_wr_t              mem_wr;
	logic                           accept;
	logic                           cfg_wr;

	assign pready = 1'b1;
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite;

	assign done         = done_q;
	assign read_value   = read_value_q;
	assign was_hit      = was_hit_q;
	assign hits_total   = hits_q;
	assign misses_total = misses_q;
	assign bytes_total  = bytes_q;
	assign cycles_total = cycles_q;

	always_comb begin
		case (paddr[2])
			sarc_pkg::REG_CACHE_COST: prdata = 32'(cac_q);
			sarc_pkg::REG_MEM_COST:   prdata = 32'(mac_q);
			default:                  prdata = '0;
		endcase
	end

	// Split the byte address into block, set and tag.
	assign in_blk   = byte_address[ADDR_W-1:OFF_W];
	assign in_set   = SET_IW'(in_blk % NUM_SETS);
	assign cache_re = accept && (func == sarc_pkg::FUNC_CACHE_READ);

	always_ff @(posedge clk) begin
		if (cache_re) begin
			off_s1  <= byte_address[OFF_W-1:0];
			set_s1  <= in_set;
			tag_s1  <= TAG_W'(in_blk / NUM_SETS);
			blk_s1  <= in_blk;
			size_s1 <= access_size;
		end
	end

	// Cache row memory: read at accept, written back at the end of the access.
	always_ff @(posedge clk) begin
		if (cache_we) begin
			cache_mem[set_s1] <= cache_wdata;
		end
		if (cache_re) begin
			row_q <= cache_mem[in_set];
		end
	end

	// Tag compare, first free way, and the stamp under the search pointer.
	always_comb begin
		vrow     = valid_q[set_s1];
		hit_way  = '0;
		free_way = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			hit_vec[w] = vrow[w] && (row_q[w][TAG_LSB +: TAG_W] == tag_s1);
		end
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = WAY_IW'(w);
			end
			if (!vrow[w]) begin
				free_way = WAY_IW'(w);
			end
		end
		any_hit   = |hit_vec;
		any_free  = ~&vrow;
		cur_stamp = row_q[sw_q][STAMP_LSB +: STAMP_W];
	end

	// Pick the requested bytes little-endian; bytes past the line end read as zero.
	assign len      = sarc_pkg::size_bytes(size_s1);
	assign line_sel = (state_q == S_LOOKUP) ? row_q[hit_way][DATA_LSB +: LINE_BITS] : fill_q;

	always_comb begin : extract
		logic [POS_W-1:0]     pos;
		logic [LINE_BITS-1:0] sh;
		ext_val = '0;
		for (int i = 0; i < 4; i++) begin
			pos = POS_W'(off_s1) + POS_W'(i);
			sh  = line_sel >> {pos, 3'b000};
			if ((sarc_pkg::LEN_W'(i) < len) && (pos < POS_W'(LINE_BYTES))) begin
				ext_val[8*i +: 8] = sh[7:0];
			end
		end
	end

	// Write-back row: a hit refreshes its stamp, a fill replaces the victim way.
	always_comb begin
		cache_wdata = row_q;
		cache_we    = 1'b0;
		if ((state_q == S_LOOKUP) && any_hit) begin
			cache_we = 1'b1;
			cache_wdata[hit_way][STAMP_LSB +: STAMP_W] = clock_q;
		end else if (state_q == S_FINISH) begin
			cache_we = 1'b1;
			cache_wdata[vic_q][DATA_LSB +: LINE_BITS] = fill_q;
			cache_wdata[vic_q][TAG_LSB +: TAG_W]      = tag_s1;
			cache_wdata[vic_q][STAMP_LSB +: STAMP_W]  = clock_q;
		end
	end

	// Backing memory: fill word k of the block; the index wraps by truncation.
	assign fidx      = (FILL_W'(blk_s1) << WPL_SH) + FILL_W'(iss_q);
	assign mem_raddr = MEM_AW'(fidx);
	assign mem_re    = (state_q == S_FILL) && (iss_q != IS_W'(WPL));

	assign mem_wr.en    = accept && (func == sarc_pkg::FUNC_MEM_WRITE);
	assign mem_wr.index = mem_word_index;
	assign mem_wr.data  = mem_word_data;

	sarc_word_mem #(
		.MEM_WORDS (MEM_WORDS)
	) u_word_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rdata   (mem_rdata)
	);

	always_ff @(posedge clk) begin
		if ((state_q == S_FILL) && rv_q) begin
			fill_q[32*widx_q +: 32] <= mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cac_q        <= sarc_pkg::CAC_RESET;
			mac_q        <= sarc_pkg::MAC_RESET;
			clock_q      <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			bytes_q      <= '0;
			cycles_q     <= '0;
			done_q       <= 1'b0;
			read_value_q <= '0;
			was_hit_q    <= 1'b0;
			iss_q        <= '0;
			rv_q         <= 1'b0;
			widx_q       <= '0;
			srch_done_q  <= 1'b0;
			sw_q         <= '0;
			vic_q        <= '0;
			best_q       <= '0;
			for (int s = 0; s < NUM_SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				case (paddr[2])
					sarc_pkg::REG_CACHE_COST: cac_q <= pwdata[sarc_pkg::CAC_W-1:0];
					sarc_pkg::REG_MEM_COST:   mac_q <= pwdata[sarc_pkg::MAC_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == sarc_pkg::FUNC_CACHE_READ) begin
							state_q <= S_LOOKUP;
						end else begin
							done_q       <= 1'b1;
							read_value_q <= '0;
							was_hit_q    <= 1'b0;
						end
					end
				end
				S_LOOKUP: begin
					cycles_q <= cycles_q + sarc_pkg::CNT_W'(cac_q);
					if (any_hit) begin
						hits_q       <= hits_q + 1'b1;
						bytes_q      <= bytes_q + sarc_pkg::CNT_W'(len);
						clock_q      <= clock_q + 1'b1;
						read_value_q <= ext_val;
						was_hit_q    <= 1'b1;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_FILL;
						iss_q   <= '0;
						rv_q    <= 1'b0;
						if (any_free) begin
							vic_q       <= free_way;
							srch_done_q <= 1'b1;
						end else begin
							// Full set: walk the ways for the oldest stamp, lowest way on ties.
							vic_q       <= '0;
							best_q      <= row_q[0][STAMP_LSB +: STAMP_W];
							sw_q        <= WAY_IW'(1);
							srch_done_q <= (NUM_WAYS == 1);
						end
					end
				end
				S_FILL: begin
					if (mem_re) begin
						iss_q <= iss_q + 1'b1;
					end
					rv_q   <= mem_re;
					widx_q <= WI_W'(iss_q);
					if (!srch_done_q) begin
						if (cur_stamp < best_q) begin
							best_q <= cur_stamp;
							vic_q  <= sw_q;
						end
						sw_q <= sw_q + 1'b1;
						if (sw_q == WAY_IW'(NUM_WAYS - 1)) begin
							srch_done_q <= 1'b1;
						end
					end
					if ((iss_q == IS_W'(WPL)) && !rv_q && srch_done_q) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					misses_q             <= misses_q + 1'b1;
					cycles_q             <= cycles_q + sarc_pkg::CNT_W'(mac_q);
					bytes_q              <= bytes_q + sarc_pkg::CNT_W'(len);
					clock_q              <= clock_q + 1'b1;
					valid_q[set_s1][vic_q] <= 1'b1;
					read_value_q         <= ext_val;
					was_hit_q            <= 1'b0;
					done_q               <= 1'b1;
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== test/set_assoc_read_cache_lru_unit_tb.sv =====
// Self-checking testbench for the set-associative read cache with LRU replacement.

typedef struct {
	logic                          func;
	logic [sarc_pkg::ADDR_W-1:0]   addr;
	logic [sarc_pkg::SIZE_W-1:0]   size;
	logic [sarc_pkg::MIDX_W-1:0]   widx;
	logic [sarc_pkg::WORD_W-1:0]   wdata;
} access_t;

typedef struct {
	logic [sarc_pkg::WORD_W-1:0] value;
	logic                        hit;
	logic [sarc_pkg::CNT_W-1:0]  hits;
	logic [sarc_pkg::CNT_W-1:0]  misses;
	logic [sarc_pkg::CNT_W-1:0]  nbytes;
	logic [sarc_pkg::CNT_W-1:0]  ncycles;
} result_t;

// Mirror of the cache, its backing memory and its totals; it also owns the
// queue of result beats that the block still owes.
class lru_cache_board;
	localparam int SETS  = 4;
	localparam int WAYS  = 2;
	localparam int WORDS = 128;

	bit        held     [SETS][WAYS];
	bit [3:0]  tag_of   [SETS][WAYS];
	bit [63:0] line_of  [SETS][WAYS];
	bit [31:0] stamp_of [SETS][WAYS];
	bit [31:0] tick;
	bit [31:0] words  [WORDS];
	bit        loaded [WORDS];
	bit [31:0] hits, misses, nbytes, ncycles;
	bit [7:0]  cache_cost;
	bit [9:0]  mem_cost;
	result_t   owed[$];
	int        faults;

	function new();
		cache_cost = sarc_pkg::CAC_RESET;
		mem_cost   = sarc_pkg::MAC_RESET;
	endfunction

	// The address splits into tag [8:5], set [4:3] and line offset [2:0].
	function bit find_way(bit [8:0] addr, output int way);
		way = 0;
		for (int w = 0; w < WAYS; w++) begin
			if (held[addr[4:3]][w] && tag_of[addr[4:3]][w] == addr[8:5]) begin
				way = w;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// True when a read of this address hits, or its refill would only
	// touch backing words that have been written since reset.
	function bit block_ready(bit [8:0] addr);
		int way;
		return find_way(addr, way) ||
			(loaded[{addr[8:3], 1'b0}] && loaded[{addr[8:3], 1'b1}]);
	endfunction

	function void note_access(access_t a);
		result_t r;
		int      way, len, off;
		bit [1:0] set;
		r = '{default: '0};
		if (a.func == sarc_pkg::FUNC_MEM_WRITE) begin
			words[a.widx]  = a.wdata;
			loaded[a.widx] = 1'b1;
		end else begin
			set = a.addr[4:3];
			off = a.addr[2:0];
			case (a.size)
				sarc_pkg::SIZE_BYTE: len = 1;
				sarc_pkg::SIZE_HALF: len = 2;
				sarc_pkg::SIZE_WORD: len = 4;
				default:             len = 0;
			endcase
			ncycles += cache_cost;
			r.hit = find_way(a.addr, way);
			if (r.hit) begin
				hits++;
			end else begin
				misses++;
				ncycles += mem_cost;
				// Lowest empty way first, else the oldest stamp (lowest way on a tie).
				way = WAYS;
				for (int w = WAYS - 1; w >= 0; w--)
					if (!held[set][w]) way = w;
				if (way == WAYS) begin
					way = 0;
					for (int w = 1; w < WAYS; w++)
						if (stamp_of[set][w] < stamp_of[set][way]) way = w;
				end
				line_of[set][way] = {words[{a.addr[8:3], 1'b1}], words[{a.addr[8:3], 1'b0}]};
				held[set][way]    = 1'b1;
				tag_of[set][way]  = a.addr[8:5];
			end
			stamp_of[set][way] = tick;
			tick++;
			for (int i = 0; i < len; i++)
				if (off + i < 8) r.value[8*i +: 8] = line_of[set][way][8*(off + i) +: 8];
			nbytes += len;
		end
		r.hits    = hits;
		r.misses  = misses;
		r.nbytes  = nbytes;
		r.ncycles = ncycles;
		owed.push_back(r);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %h, got %h", name, want, seen);
			faults++;
		end
	endfunction

	function void check_beat(result_t seen);
		result_t want;
		if (owed.size() == 0) begin
			$error("result beat with no access outstanding");
			faults++;
			return;
		end
		want = owed.pop_front();
		compare_field("read_value", want.value, seen.value);
		compare_field("was_hit", 32'(want.hit), 32'(seen.hit));
		compare_field("hits_total", want.hits, seen.hits);
		compare_field("misses_total", want.misses, seen.misses);
		compare_field("bytes_total", want.nbytes, seen.nbytes);
		compare_field("cycles_total", want.ncycles, seen.ncycles);
	endfunction
endclass

module set_assoc_read_cache_lru_unit_tb;

	// The package names the three real sizes; the fourth code is a zero-length read.
	localparam logic [sarc_pkg::SIZE_W-1:0] SIZE_NONE = 2'd3;
	// Far beyond the slowest legal run (about 1600 beats).
	localparam int LIMIT = 500000;

	logic                          clk;
	logic                          arst_n         = 1'b0;
	logic                          psel           = 1'b0;
	logic                          penable        = 1'b0;
	logic                          pwrite         = 1'b0;
	logic [2:0]                    paddr          = '0;
	logic [31:0]                   pwdata         = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          start          = 1'b0;
	logic                          busy;
	logic                          func           = sarc_pkg::FUNC_MEM_WRITE;
	logic [sarc_pkg::ADDR_W-1:0]   byte_address   = '0;
	logic [sarc_pkg::SIZE_W-1:0]   access_size    = sarc_pkg::SIZE_BYTE;
	logic [sarc_pkg::MIDX_W-1:0]   mem_word_index = '0;
	logic [sarc_pkg::WORD_W-1:0]   mem_word_data  = '0;
	logic                          done;
	logic [sarc_pkg::WORD_W-1:0]   read_value;
	logic                          was_hit;
	logic [sarc_pkg::CNT_W-1:0]    hits_total;
	logic [sarc_pkg::CNT_W-1:0]    misses_total;
	logic [sarc_pkg::CNT_W-1:0]    bytes_total;
	logic [sarc_pkg::CNT_W-1:0]    cycles_total;

	lru_cache_board board;
	// Beats left in the current burst of the sender; a gap comes when it runs out.
	int burst_left = 0;

	set_assoc_read_cache_lru_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.func(func), .byte_address(byte_address), .access_size(access_size),
		.mem_word_index(mem_word_index), .mem_word_data(mem_word_data),
		.done(done), .read_value(read_value), .was_hit(was_hit),
		.hits_total(hits_total), .misses_total(misses_total),
		.bytes_total(bytes_total), .cycles_total(cycles_total)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result beats cannot be held off, so every cycle with done high is
	// checked against the oldest prediction.
	always @(posedge clk) begin
		result_t seen;
		if (arst_n && done) begin
			seen = '{read_value, was_hit, hits_total, misses_total, bytes_total, cycles_total};
			board.check_beat(seen);
		end
	end

	// Presents one beat and returns at the edge that accepts it. When a burst
	// ends, start drops for a random gap; inside a burst it stays high and only
	// the payload changes, so start never gets two updates in one step.
	task automatic issue(input access_t a);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			if ($urandom_range(0, 5) == 0) burst_left = $urandom_range(40, 120);
			else burst_left = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		start          <= 1'b1;
		func           <= a.func;
		byte_address   <= a.addr;
		access_size    <= a.size;
		mem_word_index <= a.widx;
		mem_word_data  <= a.wdata;
		do @(posedge clk); while (busy);
		board.note_access(a);
	endtask

	// A backing-memory store; the read-only fields carry noise.
	task automatic write_word(input logic [sarc_pkg::MIDX_W-1:0] idx,
			input logic [sarc_pkg::WORD_W-1:0] data);
		access_t a;
		a.func  = sarc_pkg::FUNC_MEM_WRITE;
		a.addr  = sarc_pkg::ADDR_W'($urandom);
		a.size  = sarc_pkg::SIZE_W'($urandom);
		a.widx  = idx;
		a.wdata = data;
		issue(a);
	endtask

	// A cache read. A miss must never refill from a backing word that was not
	// written since reset, so any such word of the block is stored first.
	task automatic read_at(input logic [sarc_pkg::ADDR_W-1:0] addr,
			input logic [sarc_pkg::SIZE_W-1:0] sz);
		access_t a;
		if (!board.block_ready(addr))
			for (int k = 0; k < 2; k++)
				if (!board.loaded[{addr[8:3], k[0]}]) write_word({addr[8:3], k[0]}, $urandom);
		a.func  = sarc_pkg::FUNC_CACHE_READ;
		a.addr  = addr;
		a.size  = sz;
		a.widx  = sarc_pkg::MIDX_W'($urandom);
		a.wdata = $urandom;
		issue(a);
	endtask

	// Stops the sender and waits until every owed beat has come, plus a
	// margin longer than the slowest miss.
	task automatic settle();
		start      <= 1'b0;
		burst_left = 0;
		while (board.owed.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Each task waits for a fresh clock edge before it drives anything, so psel
	// never drops and rises in the same step.
	task automatic apb_write(input logic idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic idx, output logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data    = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Both costs are changed only with the block idle. Bits above a register's
	// width carry noise and must be dropped; a read-back confirms each value.
	task automatic set_costs(input logic [sarc_pkg::CAC_W-1:0] cc,
			input logic [sarc_pkg::MAC_W-1:0] mc);
		logic [31:0] back;
		settle();
		apb_write(sarc_pkg::REG_CACHE_COST, {24'($urandom), cc});
		apb_write(sarc_pkg::REG_MEM_COST, {22'($urandom), mc});
		board.cache_cost = cc;
		board.mem_cost   = mc;
		apb_read(sarc_pkg::REG_CACHE_COST, back);
		board.compare_field("cache_access_cost", 32'(cc), back);
		apb_read(sarc_pkg::REG_MEM_COST, back);
		board.compare_field("memory_access_cost", 32'(mc), back);
	endtask

	// Random traffic. Most reads go to a handful of hot blocks, which crowd
	// the two ways of a set and make both hits and LRU evictions common; the
	// rest spread over the whole space. Stores also land on cached words, so
	// stale lines get read back. Halfway through, the sender drains fully.
	task automatic run_random(input int n);
		logic [5:0]                  hot [6];
		logic [sarc_pkg::SIZE_W-1:0] sizes [4];
		logic [sarc_pkg::ADDR_W-1:0] addr;
		int                          r;
		sizes = '{sarc_pkg::SIZE_BYTE, sarc_pkg::SIZE_HALF, sarc_pkg::SIZE_WORD, SIZE_NONE};
		foreach (hot[i]) hot[i] = 6'($urandom);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) settle();
			r = $urandom_range(0, 99);
			if (r < 22) begin
				write_word(sarc_pkg::MIDX_W'($urandom), $urandom);
			end else begin
				if (r < 70) addr = {hot[$urandom_range(0, 5)], 3'($urandom)};
				else addr = sarc_pkg::ADDR_W'($urandom);
				read_at(addr, sizes[($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2)]);
			end
		end
	endtask

	initial begin
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset costs. Block 0 holds all ones and a
		// mixed pattern, the top block all zeros and all ones.
		write_word(7'd0, 32'hFFFF_FFFF);
		write_word(7'd1, 32'h8070_6050);
		write_word(7'd126, 32'h0000_0000);
		write_word(7'd127, 32'hFFFF_FFFF);
		read_at(9'd0, sarc_pkg::SIZE_BYTE);      // cold miss into way 0
		read_at(9'd1, sarc_pkg::SIZE_HALF);      // hit
		read_at(9'd3, sarc_pkg::SIZE_WORD);      // word that straddles the two backing words
		read_at(9'd7, sarc_pkg::SIZE_WORD);      // three bytes fall past the block end
		read_at(9'd7, sarc_pkg::SIZE_HALF);      // one byte past the end
		read_at(9'd2, SIZE_NONE);                // zero-length read still counts as a lookup
		read_at(9'd32, sarc_pkg::SIZE_WORD);     // same set, second way
		read_at(9'd0, sarc_pkg::SIZE_BYTE);      // hit refreshes way 0
		write_word(7'd0, 32'h0000_0000);
		read_at(9'd0, sarc_pkg::SIZE_WORD);      // line is stale: the old bytes come back
		read_at(9'd64, sarc_pkg::SIZE_WORD);     // full set: evicts the line of address 32
		read_at(9'd32, sarc_pkg::SIZE_HALF);     // evicts block 0, now the oldest
		read_at(9'd0, sarc_pkg::SIZE_WORD);      // refetch shows the new backing word
		read_at(9'd511, sarc_pkg::SIZE_BYTE);    // top byte of the space
		read_at(9'd508, sarc_pkg::SIZE_WORD);
		read_at(9'd504, sarc_pkg::SIZE_HALF);
		read_at(9'd511, sarc_pkg::SIZE_WORD);

		// Cost extremes first, then random settings.
		set_costs(8'hFF, 10'h3FF);
		run_random(280);
		set_costs(8'h00, 10'h000);
		run_random(280);
		repeat (3) begin
			set_costs(sarc_pkg::CAC_W'($urandom), sarc_pkg::MAC_W'($urandom));
			run_random(280);
		end

		settle();
		if (board.faults == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#LIMIT;
		$display("TEST FAILED");
		$finish;
	end

endmodule
